// ----- hw/rtl/assert_macros.svh -----
// ------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the tile decoder RTL.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk_i, disabled while rst_ni is low.
`define TRPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never hold on a clock edge.
`define TRPD_NEVER(label, cond, msg) \
  `TRPD_ASSERT(label, !(cond), msg)

`endif

// ----- hw/rtl/trpd_pkg.sv -----
// ------------------------------------------------------------------------
// trpd_pkg
// Types and constants shared by the tile decoder modules.
// ------------------------------------------------------------------------
`default_nettype none

package trpd_pkg;

  localparam int unsigned TileWidthDef = 32;
  localparam int unsigned XStepDef     = 2;
  localparam int unsigned TableDepth   = 256;
  localparam int unsigned ColorWidth   = 24;

  localparam logic [7:0] AlphaOpaque = 8'd255;
  localparam logic [7:0] AlphaBlend  = 8'd128;
  localparam logic [7:0] AnimMax     = 8'd31;

  localparam logic [5:0] UpperRow  = 6'd16;
  localparam logic [5:0] TriRows   = 6'd31;
  localparam logic [5:0] MaxHeight = 6'd32;

  typedef enum logic [1:0] {
    OP_FRAME,
    OP_PALETTE,
    OP_XLATE
  } op_e;

  typedef enum logic [1:0] {
    CFG_SHAPE,
    CFG_MASK,
    CFG_XLATE,
    CFG_HEIGHT
  } cfg_reg_e;

  typedef enum logic [2:0] {
    SHAPE_SQUARE,
    SHAPE_RLE,
    SHAPE_LTRI,
    SHAPE_RTRI,
    SHAPE_LTRAP,
    SHAPE_RTRAP
  } shape_e;

  typedef enum logic [1:0] {
    MASK_SOLID,
    MASK_CLEAR,
    MASK_RDIAG,
    MASK_LDIAG
  } mask_e;

  // Per-word decode result handed from the position walker to the pipeline.
  typedef struct packed {
    logic       has_res;
    logic       kept;
    logic [4:0] x;
    logic [4:0] y;
    logic       blend;
    logic       last;
  } walk_t;

endpackage

`default_nettype wire

// ----- hw/rtl/trpd_intf.sv -----
// ------------------------------------------------------------------------
// trpd channel interfaces
// Valid/ready channels for input words, result words and register writes.
// ------------------------------------------------------------------------
`default_nettype none

interface trpd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic        first;
  logic [7:0]  data_byte;
  logic [7:0]  table_index;
  logic [23:0] color_value;

  modport source (output valid, op, first, data_byte, table_index, color_value,
                  input ready);
  modport sink   (input valid, op, first, data_byte, table_index, color_value,
                  output ready);
endinterface

interface trpd_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] pixel_x;
  logic [4:0] pixel_y;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       pixel_valid;
  logic       animated;
  logic       last;

  modport source (output valid, pixel_x, pixel_y, red, green, blue, alpha,
                  pixel_valid, animated, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, red, green, blue, alpha,
                  pixel_valid, animated, last, output ready);
endinterface

interface trpd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] addr;
  logic [7:0] wdata;

  modport source (output valid, addr, wdata, input ready);
  modport sink   (input valid, addr, wdata, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/trpd_ram.sv -----
// ------------------------------------------------------------------------
// trpd_ram
// Generic single-write, single-read RAM with a registered read port.
// ------------------------------------------------------------------------
`default_nettype none

module trpd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read and a write of the same entry on one edge return the old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/trpd_walk.sv -----
// ------------------------------------------------------------------------
// trpd_walk
// Row and column walker: tracks the tile position and decides, for every
// frame word, where its pixel lands and whether the tile completes.
// ------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module trpd_walk #(
  parameter int unsigned TILE_WIDTH = trpd_pkg::TileWidthDef,
  parameter int unsigned X_STEP     = trpd_pkg::XStepDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic            first_i,
  input  logic [7:0]      byte_i,
  input  logic [2:0]      shape_i,
  input  logic [1:0]      mask_i,
  input  logic [5:0]      height_i,
  output trpd_pkg::walk_t walk_o
);

  import trpd_pkg::*;

  localparam int unsigned SW = $clog2(TILE_WIDTH + 256) + 2;
  typedef logic signed [SW-1:0] sval_t;
  localparam sval_t TW    = sval_t'(TILE_WIDTH);
  localparam sval_t XS    = sval_t'(X_STEP);
  localparam sval_t One   = sval_t'(1);
  localparam sval_t Zero  = sval_t'(0);
  localparam sval_t Upper = sval_t'(UpperRow);

  logic [5:0] row_q, row_d, row_c, row_inc, row_nx, height_eff, total_rows;
  logic [7:0] col_q, col_d, col_c, col_nx;
  logic [6:0] run_q, run_d, run_c, run_nx;
  logic       active, left, tri_s, emit, eor, in_tile, blend;
  sval_t      width, start, rise, skip_w, xpos, brow, diag_edge;

  always_comb begin
    // A first word restarts the tile before it is decoded.
    row_c = first_i ? '0 : row_q;
    col_c = first_i ? '0 : col_q;
    run_c = first_i ? '0 : run_q;

    if (height_i == '0) begin
      height_eff = 6'd1;
    end else if (height_i > MaxHeight) begin
      height_eff = MaxHeight;
    end else begin
      height_eff = height_i;
    end

    if (shape_i inside {SHAPE_SQUARE, SHAPE_RLE}) begin
      total_rows = height_eff;
    end else if (shape_i inside {SHAPE_LTRI, SHAPE_RTRI}) begin
      total_rows = TriRows;
    end else begin
      total_rows = MaxHeight;
    end

    active = (shape_i <= SHAPE_RTRAP) && (row_c < total_rows);
    left   = shape_i inside {SHAPE_LTRI, SHAPE_LTRAP};
    tri_s  = shape_i inside {SHAPE_LTRI, SHAPE_RTRI};

    // Geometry of the current row.
    width = TW;
    start = '0;
    rise  = XS * (sval_t'(row_c) - Upper + One);
    if (!(shape_i inside {SHAPE_SQUARE, SHAPE_RLE})) begin
      if (row_c < UpperRow) begin
        width = XS * (sval_t'(row_c) + One);
        if (left) begin
          start = TW - width;
        end
      end else if (tri_s) begin
        width = TW - rise;
        if (left) begin
          start = rise;
        end
      end
    end

    // Upper triangle rows only shrink, so the first empty one ends the tile.
    row_inc = row_c + 6'd1;
    skip_w  = TW - XS * (sval_t'(row_inc) - Upper + One);
    row_nx  = row_inc;
    if (tri_s && row_inc >= UpperRow && row_inc < TriRows && skip_w <= Zero) begin
      row_nx = TriRows;
    end

    xpos    = start + sval_t'(col_c);
    brow    = sval_t'(height_eff) - One - sval_t'(row_c);
    in_tile = (xpos >= Zero) && (xpos < TW) && (brow >= Zero);

    col_nx = col_c + 8'd1;
    run_nx = run_c;
    emit   = 1'b1;
    if (shape_i == SHAPE_RLE) begin
      if (run_c != '0) begin
        run_nx = run_c - 7'd1;
      end else begin
        emit   = 1'b0;
        col_nx = col_c;
        if (byte_i[7]) begin
          col_nx = col_c - byte_i;
        end else begin
          run_nx = byte_i[6:0];
        end
      end
      eor = (run_nx == '0) && (sval_t'(col_nx) >= TW);
    end else begin
      eor = sval_t'(col_nx) >= width;
    end

    row_d = row_c;
    col_d = col_nx;
    run_d = run_nx;
    if (eor) begin
      row_d = row_nx;
      col_d = '0;
      run_d = '0;
    end
    if (!active) begin
      row_d = row_c;
      col_d = col_c;
      run_d = run_c;
    end

    diag_edge = XS * (brow + One);
    blend     = 1'b0;
    if (brow < Upper) begin
      if (mask_i == MASK_RDIAG) begin
        blend = (diag_edge < TW) && (xpos >= diag_edge);
      end else if (mask_i == MASK_LDIAG) begin
        blend = ((TW - diag_edge) > Zero) && (xpos < TW - diag_edge);
      end
    end

    walk_o.has_res = active;
    walk_o.kept    = active && emit && in_tile;
    walk_o.x       = xpos[4:0];
    walk_o.y       = brow[4:0];
    walk_o.blend   = blend;
    walk_o.last    = row_d >= total_rows;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      run_q <= '0;
    end else if (step_i) begin
      row_q <= row_d;
      col_q <= col_d;
      run_q <= run_d;
    end
  end

  // Without a restart the row count only moves forward.
  `TRPD_ASSERT(a_row_monotonic, step_i && !first_i |=> row_q >= $past(row_q),
               "row count went backward without a first word")
  // Once a word completes the tile, the next word gives no result unless it restarts.
  `TRPD_ASSERT(a_done_quiet, step_i && active && walk_o.last |=> !(step_i && !first_i && active),
               "tile still active after its completing word")

endmodule

`default_nettype wire

// ----- hw/rtl/tile_rle_palette_decoder_core.sv -----
// ------------------------------------------------------------------------
// tile_rle_palette_decoder_core
// Decodes a tile byte stream into palette-expanded RGBA pixels, one word
// per cycle unless out_o stalls, through an optional translation RAM and a palette RAM.
// ------------------------------------------------------------------------
//  Channel | Role | Carries
//  --------+------+--------------------------------------------------------
//  in_i    | sink | op, first, data_byte, table_index, color_value
//  out_o   | src  | pixel_x/y, red, green, blue, alpha, pixel_valid, ...
//  cfg_i   | sink | register index and write data, always ready
//
// One input word per cycle unless out_o stalls; results cross s1, s2 and out.
// The translation read and the dependent palette read are each registered.
// Table contents are undefined after reset; there is no clearing pass.
// Input ready drops only when all three stages hold words and out_o stalls.
// ------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tile_rle_palette_decoder_core #(
  parameter int unsigned TILE_WIDTH = trpd_pkg::TileWidthDef,
  parameter int unsigned X_STEP     = trpd_pkg::XStepDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  trpd_in_if.sink   in_i,
  trpd_out_if.source out_o,
  trpd_cfg_if.sink  cfg_i
);

  import trpd_pkg::*;

  logic [2:0]            shape_q;
  logic [1:0]            mask_q;
  logic                  xlate_q;
  logic [5:0]            height_q;

  logic                  in_ready, in_fire, frame_fire, adv_s2, adv_out;
  walk_t                 walk;

  logic                  s1_vld_q, s1_res_q, s1_clr_q;
  walk_t                 s1_walk_q;
  logic [7:0]            s1_idx_q;

  logic                  s2_vld_q, s2_res_q, s2_anim_q;
  walk_t                 s2_walk_q;

  logic                  anim_q, anim_d, anim_hit;

  logic                  out_vld_q, out_anim_q;
  walk_t                 out_walk_q;
  logic [ColorWidth-1:0] out_color_q;

  logic [7:0]            xlate_rdata, pal_raddr;
  logic [ColorWidth-1:0] pal_rdata;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q  <= SHAPE_SQUARE;
      mask_q   <= MASK_SOLID;
      xlate_q  <= 1'b0;
      height_q <= MaxHeight;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.addr))
        CFG_SHAPE:  shape_q  <= cfg_i.wdata[2:0];
        CFG_MASK:   mask_q   <= cfg_i.wdata[1:0];
        CFG_XLATE:  xlate_q  <= cfg_i.wdata[0];
        CFG_HEIGHT: height_q <= cfg_i.wdata[5:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow: every stage moves when the one after it is empty or moving.
  assign adv_out    = !out_vld_q || out_o.ready;
  assign adv_s2     = !s2_vld_q || adv_out;
  assign in_ready   = !s1_vld_q || adv_s2;
  assign in_i.ready = in_ready;
  assign in_fire    = in_i.valid && in_ready;
  assign frame_fire = in_fire && (in_i.op == OP_FRAME);

  trpd_walk #(
    .TILE_WIDTH (TILE_WIDTH),
    .X_STEP     (X_STEP)
  ) u_walk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (frame_fire),
    .first_i  (in_i.first),
    .byte_i   (in_i.data_byte),
    .shape_i  (shape_q),
    .mask_i   (mask_q),
    .height_i (height_q),
    .walk_o   (walk)
  );

  // Table writes land on the accept edge, so any later word's read sees them
  // and an earlier word still in flight reads before them.
  trpd_ram #(
    .WIDTH (8),
    .DEPTH (TableDepth)
  ) u_xlate_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire && (in_i.op == OP_XLATE)),
    .waddr_i (in_i.table_index),
    .wdata_i (in_i.data_byte),
    .re_i    (in_ready),
    .raddr_i (in_i.data_byte),
    .rdata_o (xlate_rdata)
  );

  assign pal_raddr = xlate_q ? xlate_rdata : s1_idx_q;

  trpd_ram #(
    .WIDTH (ColorWidth),
    .DEPTH (TableDepth)
  ) u_pal_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire && (in_i.op == OP_PALETTE)),
    .waddr_i (in_i.table_index),
    .wdata_i (in_i.color_value),
    .re_i    (adv_s2),
    .raddr_i (pal_raddr),
    .rdata_o (pal_rdata)
  );

  // The animated flag depends on the translated index, so it is kept here.
  always_comb begin
    anim_hit = s1_res_q && s1_walk_q.kept && (pal_raddr != '0) && (pal_raddr <= AnimMax);
    anim_d   = anim_q;
    if (adv_s2 && s1_vld_q) begin
      anim_d = (s1_clr_q ? 1'b0 : anim_q) | anim_hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s1_res_q  <= 1'b0;
      s1_clr_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s2_res_q  <= 1'b0;
      anim_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      anim_q <= anim_d;
      if (in_ready) begin
        s1_vld_q <= in_i.valid;
        s1_res_q <= frame_fire && walk.has_res;
        s1_clr_q <= frame_fire && in_i.first;
      end
      if (adv_s2) begin
        s2_vld_q <= s1_vld_q;
        s2_res_q <= s1_res_q;
      end
      if (adv_out) begin
        out_vld_q <= s2_vld_q && s2_res_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready) begin
      s1_walk_q <= walk;
      s1_idx_q  <= in_i.data_byte;
    end
    if (adv_s2) begin
      s2_walk_q <= s1_walk_q;
      s2_anim_q <= anim_d;
    end
    if (adv_out) begin
      out_walk_q  <= s2_walk_q;
      out_anim_q  <= s2_anim_q;
      out_color_q <= s2_walk_q.kept ? pal_rdata : '0;
    end
  end

  // Words without a pixel carry zero position, color and alpha.
  assign out_o.valid       = out_vld_q;
  assign out_o.pixel_x     = out_walk_q.kept ? out_walk_q.x : '0;
  assign out_o.pixel_y     = out_walk_q.kept ? out_walk_q.y : '0;
  assign out_o.red         = out_color_q[23:16];
  assign out_o.green       = out_color_q[15:8];
  assign out_o.blue        = out_color_q[7:0];
  assign out_o.alpha       = !out_walk_q.kept ? '0 :
                             (out_walk_q.blend ? AlphaBlend : AlphaOpaque);
  assign out_o.pixel_valid = out_walk_q.kept;
  assign out_o.animated    = out_anim_q;
  assign out_o.last        = out_walk_q.last;

  // Input backpressure only comes from a completely full pipeline.
  `TRPD_NEVER(a_stall_cause, !in_ready && !(s1_vld_q && s2_vld_q && out_vld_q && !out_o.ready),
              "input stalled while the pipeline had room")
  // A restarting word without an animated pixel leaves the flag clear.
  `TRPD_ASSERT(a_anim_clear, adv_s2 && s1_vld_q && s1_clr_q && !anim_hit |=> !anim_q,
               "animated flag survived a tile restart")

endmodule

`default_nettype wire
